>>> src/lav_pkg.sv
package lav_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int EPS_W      = 16;
    localparam int IN_DATA_W  = 6 * COORD_W;
    localparam int COL_IDX_W  = 2;
    localparam int OUT_PAD_W  = 6;
    localparam int OUT_DATA_W = COL_IDX_W + 4 * COORD_W + OUT_PAD_W;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
    localparam logic [COL_IDX_W-1:0] LAST_COL = 2'd3;

    localparam logic [COORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // eye point and raw forward vector (target - eye)
    typedef struct packed {
        logic [2:0][COORD_W-1:0] eye;
        logic [2:0][DIFF_W-1:0]  fwd;
    } lav_req_t;

    typedef struct packed {
        logic                   start;
        logic [2:0][DIFF_W-1:0] vec;
    } lav_nrm_req_t;

    typedef enum logic [2:0] {
        NRM_IDLE,
        NRM_SQ,
        NRM_ROOT,
        NRM_CHK,
        NRM_DIV
    } nrm_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM_F,
        BK_NORM_R,
        BK_MAC,
        BK_HAND
    } bk_state_t;

endpackage

>>> src/lav_front.sv
module lav_front import lav_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_DATA_W-1:0] s_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lav_req_t             out_req
);

    logic     valid_reg;
    lav_req_t req_reg;
    lav_req_t req_next;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_req   = req_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            req_next.eye[i] = s_data[i*COORD_W +: COORD_W];
            req_next.fwd[i] = DIFF_W'($signed(s_data[(i+3)*COORD_W +: COORD_W]))
                            - DIFF_W'($signed(s_data[i*COORD_W +: COORD_W]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= req_next;
        end
    end

endmodule

>>> src/lav_queue.sv
module lav_queue import lav_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  lav_req_t in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output lav_req_t out_req
);

    lav_req_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_req   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

>>> src/lav_norm.sv
module lav_norm import lav_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int V_W       = 18
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [EPS_W-1:0]      eps,
    input  lav_nrm_req_t          req,
    output logic                  done,
    output logic [2:0][V_W-1:0]   vec_out
);

    localparam int QW        = FRAC_BITS + 1;
    localparam int NUM_W     = FRAC_BITS + 32;
    localparam int CNT_W     = 6;
    localparam int SQ_LAST   = 3;
    localparam int ROOT_LAST = 31;

    nrm_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [1:0]           idx_reg;
    logic [2:0]           neg_reg;
    logic [2:0][30:0]     c_reg;
    logic [2:0][V_W-1:0]  raw_reg;
    logic                 shift_reg;
    logic [61:0]          sq_reg;
    logic [63:0]          sum_reg;
    logic [63:0]          rad_reg;
    logic [31:0]          root_reg;
    logic [33:0]          rem_reg;
    logic [31:0]          drem_reg;
    logic [QW-1:0]        dq_reg;
    logic                 done_reg;
    logic [2:0][V_W-1:0]  out_reg;

    logic [2:0][31:0]     mag;
    logic                 any_big;
    logic [35:0]          r_trial;
    logic [35:0]          r_test;
    logic                 r_ge;
    logic [32:0]          len_sh;
    logic                 skip;
    logic [NUM_W-1:0]     num;
    logic [32:0]          d_trial;
    logic                 d_ge;
    logic [QW-1:0]        dq_next;
    logic [V_W-1:0]       q_ext;
    logic [V_W-1:0]       q_signed;

    assign done    = done_reg;
    assign vec_out = out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = req.vec[i][DIFF_W-1] ? 32'(-req.vec[i]) : req.vec[i][31:0];
        end
        any_big = mag[0][31] | mag[1][31] | mag[2][31];

        // one root bit per cycle
        r_trial = {rem_reg, rad_reg[63:62]};
        r_test  = {2'b00, root_reg, 2'b01};
        r_ge    = r_trial >= r_test;

        len_sh = shift_reg ? {root_reg, 1'b0} : {1'b0, root_reg};
        skip   = (len_sh <= 33'(eps)) || (root_reg == '0);

        // dividend rounds to nearest: c * 2^F + len/2
        num = NUM_W'({c_reg[idx_reg], FRAC_BITS'(0)}) + NUM_W'(root_reg[31:1]);

        d_trial  = {drem_reg, dq_reg[QW-1]};
        d_ge     = d_trial >= {1'b0, root_reg};
        dq_next  = {dq_reg[QW-2:0], d_ge};
        q_ext    = V_W'(dq_next);
        q_signed = neg_reg[idx_reg] ? -q_ext : q_ext;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            NRM_IDLE: begin
                if (req.start) begin
                    state_next = NRM_SQ;
                end
            end
            NRM_SQ: begin
                if (cnt_reg == CNT_W'(SQ_LAST)) begin
                    state_next = NRM_ROOT;
                end
            end
            NRM_ROOT: begin
                if (cnt_reg == CNT_W'(ROOT_LAST)) begin
                    state_next = NRM_CHK;
                end
            end
            NRM_CHK: begin
                state_next = skip ? NRM_IDLE : NRM_DIV;
            end
            NRM_DIV: begin
                if (cnt_reg == CNT_W'(QW) && idx_reg == 2'd2) begin
                    state_next = NRM_IDLE;
                end
            end
            default: state_next = NRM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NRM_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_next != state_reg) begin
                cnt_reg <= '0;
            end else if (state_reg == NRM_DIV && cnt_reg == CNT_W'(QW)) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == NRM_CHK) begin
                idx_reg  <= '0;
                done_reg <= skip;
            end
            if (state_reg == NRM_DIV && cnt_reg == CNT_W'(QW)) begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 2'd2) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            NRM_IDLE: begin
                if (req.start) begin
                    for (int i = 0; i < 3; i++) begin
                        neg_reg[i] <= req.vec[i][DIFF_W-1];
                        c_reg[i]   <= any_big ? mag[i][31:1] : mag[i][30:0];
                        raw_reg[i] <= req.vec[i][V_W-1:0];
                    end
                    shift_reg <= any_big;
                    sum_reg   <= '0;
                end
            end
            NRM_SQ: begin
                if (cnt_reg != CNT_W'(SQ_LAST)) begin
                    sq_reg <= c_reg[cnt_reg[1:0]] * c_reg[cnt_reg[1:0]];
                end
                if (cnt_reg != '0) begin
                    sum_reg <= sum_reg + 64'(sq_reg);
                end
                if (cnt_reg == CNT_W'(SQ_LAST)) begin
                    rad_reg  <= sum_reg + 64'(sq_reg);
                    root_reg <= '0;
                    rem_reg  <= '0;
                end
            end
            NRM_ROOT: begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (r_ge) begin
                    rem_reg  <= 34'(r_trial - r_test);
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= r_trial[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            NRM_CHK: begin
                if (skip) begin
                    out_reg <= raw_reg;
                end
            end
            NRM_DIV: begin
                if (cnt_reg == '0) begin
                    drem_reg <= 32'(num[NUM_W-1:QW]);
                    dq_reg   <= num[QW-1:0];
                end else begin
                    drem_reg <= d_ge ? 32'(d_trial - {1'b0, root_reg}) : d_trial[31:0];
                    dq_reg   <= dq_next;
                    if (cnt_reg == CNT_W'(QW)) begin
                        out_reg[idx_reg] <= q_signed;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/lav_back.sv
module lav_back import lav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [EPS_W-1:0]      eps,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lav_req_t              req,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    // unit vectors need FRAC_BITS+1 magnitude bits, raw short ones 16
    localparam int V_W    = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
    localparam int U_W    = 2 * V_W - FRAC_BITS - 1;
    localparam int A_W    = U_W;
    localparam int P_W    = A_W + COORD_W;
    localparam int ACC_W  = P_W + 2;
    localparam int RS_W   = ACC_W - FRAC_BITS;
    localparam int N_TERM = 15;
    localparam int TC_W   = 5;
    localparam int MAC_END = N_TERM + 1;
    localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] HALF_M1 = HALF - 1'b1;
    localparam logic [COORD_W-1:0] ONE   = COORD_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        DST_U0,
        DST_U1,
        DST_U2,
        DST_DR,
        DST_DF,
        DST_DU
    } mac_dst_t;

    bk_state_t                 state_reg, state_next;
    logic [2:0][COORD_W-1:0]   eye_reg;
    logic [2:0][V_W-1:0]       f_reg;
    logic [2:0][V_W-1:0]       r_reg;
    logic [2:0][U_W-1:0]       u_reg;
    logic [2:0][COORD_W-1:0]   d_reg;
    logic [TC_W-1:0]           tcnt_reg;

    lav_nrm_req_t              nreq;
    logic                      n_done;
    logic [2:0][V_W-1:0]       n_vec;
    logic [2:0][DIFF_W-1:0]    r_seed;

    logic                      issue;
    logic signed [A_W-1:0]     ta;
    logic signed [COORD_W-1:0] tb;
    logic                      tneg;
    logic                      tfirst;
    logic                      tlast;
    mac_dst_t                  tdst;

    logic                      p_vld_reg;
    logic signed [P_W-1:0]     p_reg;
    logic                      p_neg_reg;
    logic                      p_first_reg;
    logic                      p_last_reg;
    mac_dst_t                  p_dst_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   p_ext;
    logic                      fin_vld_reg;
    mac_dst_t                  fin_dst_reg;
    logic signed [ACC_W-1:0]   rnd;
    logic [RS_W-1:0]           rs;
    logic [COORD_W-1:0]        rs_sat;

    logic [2:0][COORD_W-1:0]   ob_reg [4];
    logic [COL_IDX_W-1:0]      col_reg;
    logic                      obuf_full_reg;

    lav_norm #(
        .FRAC_BITS (FRAC_BITS),
        .V_W       (V_W)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eps     (eps),
        .req     (nreq),
        .done    (n_done),
        .vec_out (n_vec)
    );

    // right = (-Fz, 0, Fx), fed straight from the forward result
    always_comb begin
        r_seed[0] = -DIFF_W'($signed(n_vec[2]));
        r_seed[1] = '0;
        r_seed[2] = DIFF_W'($signed(n_vec[0]));
    end

    always_comb begin
        state_next = state_reg;
        req_ready  = 1'b0;
        nreq.start = 1'b0;
        nreq.vec   = req.fwd;
        case (state_reg)
            BK_IDLE: begin
                if (req_valid) begin
                    req_ready  = 1'b1;
                    nreq.start = 1'b1;
                    state_next = BK_NORM_F;
                end
            end
            BK_NORM_F: begin
                nreq.vec = r_seed;
                if (n_done) begin
                    nreq.start = 1'b1;
                    state_next = BK_NORM_R;
                end
            end
            BK_NORM_R: begin
                if (n_done) begin
                    state_next = BK_MAC;
                end
            end
            BK_MAC: begin
                if (tcnt_reg == TC_W'(MAC_END)) begin
                    state_next = BK_HAND;
                end
            end
            BK_HAND: begin
                if (!obuf_full_reg) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // product schedule: U = R x F, then -R.E, F.E, -U.E
    always_comb begin
        issue  = (state_reg == BK_MAC) && (tcnt_reg < TC_W'(N_TERM));
        ta     = '0;
        tb     = '0;
        tneg   = 1'b0;
        tfirst = 1'b0;
        tlast  = 1'b0;
        tdst   = DST_U0;
        case (tcnt_reg[3:0])
            4'd0: begin
                ta = A_W'($signed(r_reg[1])); tb = COORD_W'($signed(f_reg[2]));
                tfirst = 1'b1; tdst = DST_U0;
            end
            4'd1: begin
                ta = A_W'($signed(r_reg[2])); tb = COORD_W'($signed(f_reg[1]));
                tneg = 1'b1; tlast = 1'b1; tdst = DST_U0;
            end
            4'd2: begin
                ta = A_W'($signed(r_reg[2])); tb = COORD_W'($signed(f_reg[0]));
                tfirst = 1'b1; tdst = DST_U1;
            end
            4'd3: begin
                ta = A_W'($signed(r_reg[0])); tb = COORD_W'($signed(f_reg[2]));
                tneg = 1'b1; tlast = 1'b1; tdst = DST_U1;
            end
            4'd4: begin
                ta = A_W'($signed(r_reg[0])); tb = COORD_W'($signed(f_reg[1]));
                tfirst = 1'b1; tdst = DST_U2;
            end
            4'd5: begin
                ta = A_W'($signed(r_reg[1])); tb = COORD_W'($signed(f_reg[0]));
                tneg = 1'b1; tlast = 1'b1; tdst = DST_U2;
            end
            4'd6: begin
                ta = A_W'($signed(r_reg[0])); tb = $signed(eye_reg[0]);
                tneg = 1'b1; tfirst = 1'b1; tdst = DST_DR;
            end
            4'd7: begin
                ta = A_W'($signed(r_reg[1])); tb = $signed(eye_reg[1]);
                tneg = 1'b1; tdst = DST_DR;
            end
            4'd8: begin
                ta = A_W'($signed(r_reg[2])); tb = $signed(eye_reg[2]);
                tneg = 1'b1; tlast = 1'b1; tdst = DST_DR;
            end
            4'd9: begin
                ta = A_W'($signed(f_reg[0])); tb = $signed(eye_reg[0]);
                tfirst = 1'b1; tdst = DST_DF;
            end
            4'd10: begin
                ta = A_W'($signed(f_reg[1])); tb = $signed(eye_reg[1]);
                tdst = DST_DF;
            end
            4'd11: begin
                ta = A_W'($signed(f_reg[2])); tb = $signed(eye_reg[2]);
                tlast = 1'b1; tdst = DST_DF;
            end
            4'd12: begin
                ta = $signed(u_reg[0]); tb = $signed(eye_reg[0]);
                tneg = 1'b1; tfirst = 1'b1; tdst = DST_DU;
            end
            4'd13: begin
                ta = $signed(u_reg[1]); tb = $signed(eye_reg[1]);
                tneg = 1'b1; tdst = DST_DU;
            end
            4'd14: begin
                ta = $signed(u_reg[2]); tb = $signed(eye_reg[2]);
                tneg = 1'b1; tlast = 1'b1; tdst = DST_DU;
            end
            default: ;
        endcase
    end

    always_comb begin
        acc_base = p_first_reg ? '0 : acc_reg;
        p_ext    = ACC_W'(p_reg);
        // divide by 2^F, half away from zero, in one add
        rnd      = acc_reg + (acc_reg[ACC_W-1] ? HALF_M1 : HALF);
        rs       = RS_W'(rnd >>> FRAC_BITS);
        if ((&rs[RS_W-1:COORD_W-1]) || !(|rs[RS_W-1:COORD_W-1])) begin
            rs_sat = rs[COORD_W-1:0];
        end else begin
            rs_sat = rs[RS_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            tcnt_reg      <= '0;
            p_vld_reg     <= 1'b0;
            fin_vld_reg   <= 1'b0;
            obuf_full_reg <= 1'b0;
            col_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            tcnt_reg    <= (state_reg == BK_MAC) ? tcnt_reg + 1'b1 : '0;
            p_vld_reg   <= issue;
            fin_vld_reg <= p_vld_reg && p_last_reg;
            if (state_reg == BK_HAND && !obuf_full_reg) begin
                obuf_full_reg <= 1'b1;
                col_reg       <= '0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                col_reg <= col_reg + 1'b1;
                if (col_reg == LAST_COL) begin
                    obuf_full_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_IDLE && req_ready) begin
            eye_reg <= req.eye;
        end
        if (state_reg == BK_NORM_F && n_done) begin
            f_reg <= n_vec;
        end
        if (state_reg == BK_NORM_R && n_done) begin
            r_reg <= n_vec;
        end

        p_reg       <= ta * tb;
        p_neg_reg   <= tneg;
        p_first_reg <= tfirst;
        p_last_reg  <= tlast;
        p_dst_reg   <= tdst;

        if (p_vld_reg) begin
            acc_reg     <= p_neg_reg ? acc_base - p_ext : acc_base + p_ext;
            fin_dst_reg <= p_dst_reg;
        end

        if (fin_vld_reg) begin
            case (fin_dst_reg)
                DST_U0:  u_reg[0] <= rs[U_W-1:0];
                DST_U1:  u_reg[1] <= rs[U_W-1:0];
                DST_U2:  u_reg[2] <= rs[U_W-1:0];
                DST_DR:  d_reg[0] <= rs_sat;
                DST_DU:  d_reg[1] <= rs_sat;
                DST_DF:  d_reg[2] <= rs_sat;
                default: ;
            endcase
        end

        if (state_reg == BK_HAND && !obuf_full_reg) begin
            for (int i = 0; i < 3; i++) begin
                ob_reg[i][0] <= COORD_W'($signed(r_reg[i]));
                ob_reg[i][1] <= COORD_W'($signed(u_reg[i]));
                ob_reg[i][2] <= -COORD_W'($signed(f_reg[i]));
            end
            ob_reg[3] <= d_reg;
        end
    end

    assign m_axis_tvalid = obuf_full_reg;
    assign m_axis_tlast  = col_reg == LAST_COL;
    assign m_axis_tdata  = {
        OUT_PAD_W'(0),
        (col_reg == LAST_COL) ? ONE : COORD_W'(0),
        ob_reg[col_reg][2],
        ob_reg[col_reg][1],
        ob_reg[col_reg][0],
        col_reg
    };

endmodule

>>> src/look_at_view_matrix_top.sv
// Look-at view matrix: each request carries an eye and a target point (signed
// fixed point, FRAC_BITS fraction bits) and yields four column results of the
// 4x4 view matrix in column-major order, the fourth marked with tlast. The
// single shared normalizer forms the square root one bit per cycle and each
// of the three quotients one bit per cycle, runs once for the forward and once
// for the right vector, and skips the quotients when a vector is too short to
// normalize. Cross and dot products then go through one multiplier. Up to
// three further requests are buffered ahead of the normalizer, and the four
// columns of one request drain while the next one is computed. norm_epsilon
// is written through cfg_we and cfg_wdata; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module look_at_view_matrix_top import lav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [EPS_W-1:0]      cfg_wdata,      // norm_epsilon
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // column_index, elem_row0, elem_row1, elem_row2, elem_row3, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // last_column
);

    logic [EPS_W-1:0] eps_reg;
    logic             fr_valid;
    logic             fr_ready;
    lav_req_t         fr_req;
    logic             q_valid;
    logic             q_ready;
    lav_req_t         q_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    lav_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_req   (fr_req)
    );

    lav_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_req    (fr_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_req   (q_req)
    );

    lav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .eps           (eps_reg),
        .req_valid     (q_valid),
        .req_ready     (q_ready),
        .req           (q_req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> src/lav_checker.sv
module lav_checker import lav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == LAST_COL)))
        else $error("tlast does not match column index");

    // the columns of one request leave back to back, in order
    a_col_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[1:0] == 2'($past(m_axis_tdata[1:0]) + 2'd1)))
        else $error("column sequence broken");

    a_row3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[129:98] == (m_axis_tlast ? ONE : COORD_W'(0))))
        else $error("bottom row entry wrong");

endmodule

bind look_at_view_matrix_top lav_checker #(.FRAC_BITS(FRAC_BITS)) u_lav_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> test/look_at_view_matrix_checker.sv
module look_at_view_matrix_checker import lav_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [EPS_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    fail_count,
    output int                    columns_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint vec3_t [3];

    typedef struct packed {
        logic [COL_IDX_W-1:0]    idx;
        logic [3:0][COORD_W-1:0] rows;
        logic                    last;
    } column_t;

    logic [EPS_W-1:0] epsilon;
    column_t          column_q [$];

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint descale(longint v);
        longint unsigned q;
        q = (mag(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [COORD_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return SAT_MAX;
        if (v < -64'sd2147483648)
            return SAT_MIN;
        return v[COORD_W-1:0];
    endfunction

    // unit-length scaling, skipped when the vector is at or below epsilon
    function automatic vec3_t unit_vec(vec3_t v, logic [EPS_W-1:0] eps);
        longint unsigned m [3];
        longint unsigned c;
        longint unsigned acc;
        longint unsigned len;
        longint unsigned q;
        int              s;
        vec3_t           o;
        for (int i = 0; i < 3; i++)
            m[i] = mag(v[i]);
        s = 0;
        while (s < 40 && ((m[0] >> s) >= 64'h8000_0000 || (m[1] >> s) >= 64'h8000_0000 ||
                          (m[2] >> s) >= 64'h8000_0000))
            s++;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            c = m[i] >> s;
            acc += c * c;
        end
        len = floor_sqrt(acc);
        o = v;
        if ((len << s) <= longint'(eps) || len == 0)
            return o;
        for (int i = 0; i < 3; i++) begin
            c = m[i] >> s;
            q = ((c << FRAC_BITS) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    task automatic predict_columns(logic [IN_DATA_W-1:0] req);
        vec3_t   e, f, r, u;
        longint  c3 [3];
        column_t col;
        for (int i = 0; i < 3; i++) begin
            e[i] = longint'($signed(req[32*i +: 32]));
            f[i] = longint'($signed(req[32*(i+3) +: 32])) - e[i];
        end
        f = unit_vec(f, epsilon);
        r[0] = -f[2];
        r[1] = 0;
        r[2] = f[0];
        r = unit_vec(r, epsilon);
        u[0] = descale(r[1] * f[2] - r[2] * f[1]);
        u[1] = descale(r[2] * f[0] - r[0] * f[2]);
        u[2] = descale(r[0] * f[1] - r[1] * f[0]);
        c3[0] = -descale(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
        c3[1] = -descale(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]);
        c3[2] = descale(f[0] * e[0] + f[1] * e[1] + f[2] * e[2]);
        for (int k = 0; k < 4; k++) begin
            col.idx  = k[COL_IDX_W-1:0];
            col.last = (col.idx == LAST_COL);
            if (k < 3) begin
                col.rows[0] = clamp32(r[k]);
                col.rows[1] = clamp32(u[k]);
                col.rows[2] = clamp32(-f[k]);
                col.rows[3] = '0;
            end else begin
                col.rows[0] = clamp32(c3[0]);
                col.rows[1] = clamp32(c3[1]);
                col.rows[2] = clamp32(c3[2]);
                col.rows[3] = COORD_W'(1) << FRAC_BITS;
            end
            column_q.push_back(col);
        end
    endtask

    initial begin
        fail_count = 0;
        epsilon    = EPS_RESET;
    end

    assign columns_pending = column_q.size();

    always @(posedge aclk) begin
        column_t          want;
        logic [COORD_W-1:0] got;
        if (!aresetn) begin
            epsilon <= EPS_RESET;
        end else begin
            if (cfg_we)
                epsilon <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                predict_columns(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (column_q.size() == 0) begin
                    $display("%0t: unexpected column %h", $realtime, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = column_q.pop_front();
                    if (m_axis_tdata[COL_IDX_W-1:0] !== want.idx) begin
                        $display("%0t: column_index exp %0d got %0d", $realtime, want.idx,
                                 m_axis_tdata[COL_IDX_W-1:0]);
                        fail_count++;
                    end
                    for (int k = 0; k < 4; k++) begin
                        got = m_axis_tdata[COL_IDX_W + 32*k +: 32];
                        if (got !== want.rows[k]) begin
                            $display("%0t: col %0d row %0d exp %h got %h", $realtime,
                                     want.idx, k, want.rows[k], got);
                            fail_count++;
                        end
                    end
                    if (m_axis_tlast !== want.last) begin
                        $display("%0t: col %0d tlast exp %b got %b", $realtime, want.idx,
                                 want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_look_at_view_matrix_top.sv
module tb_look_at_view_matrix_top;
    import lav_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [EPS_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int fail_count;
    int columns_pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;

    look_at_view_matrix_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    look_at_view_matrix_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .columns_pending (columns_pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int span_rand(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_request(int ex, int ey, int ez, int tx, int ty, int tz);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tz, ty, tx, ez, ey, ex};
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_random;
        int ex, ey, ez, tx, ty, tz;
        int pick;
        pick = $urandom_range(99);
        ex = span_rand(1 << 26);
        ey = span_rand(1 << 26);
        ez = span_rand(1 << 26);
        tx = ex + span_rand(1 << 22);
        ty = ey + span_rand(1 << 22);
        tz = ez + span_rand(1 << 22);
        if (pick < 15) begin
            // straight up or down
            tx = ex;
            tz = ez;
        end else if (pick < 25) begin
            tx = ex + span_rand(3);
            ty = ey + span_rand(3);
            tz = ez + span_rand(3);
        end else if (pick < 35) begin
            tx = ex + span_rand(8);
            tz = ez + span_rand(8);
        end else if (pick < 60) begin
            ex = $urandom;
            ey = $urandom;
            ez = $urandom;
            tx = $urandom;
            ty = $urandom;
            tz = $urandom;
        end
        send_request(ex, ey, ez, tx, ty, tz);
    endtask

    task automatic settle_and_write(logic [EPS_W-1:0] eps);
        s_axis_tvalid <= 1'b0;
        while (columns_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= eps;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    localparam int MAXP = 32'h7fff_ffff;
    localparam int MINN = 32'h8000_0000;
    localparam int ONE  = 32'h0001_0000;

    initial begin
        int phase_idle  [4] = '{0, 86, 0, 17};
        int phase_stall [4] = '{0, 0, 86, 17};
        logic [EPS_W-1:0] phase_eps [4];
        phase_eps[0] = 16'd0;
        phase_eps[1] = 16'hffff;
        phase_eps[2] = EPS_RESET;
        phase_eps[3] = EPS_W'($urandom);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset epsilon, no idling
        send_request(0, 0, 0, 0, 0, 0);
        send_request(0, 0, 0, 0, 0, -ONE);
        send_request(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE);
        send_request(5, 5, 5, 8, 9, 10);
        send_request(0, 0, 0, 0, ONE, 0);
        send_request(0, 0, 0, 0, -ONE, 0);
        send_request(ONE, ONE, ONE, ONE + 1, 9 * ONE, ONE);
        send_request(0, 0, 0, 2, 0, 2);
        send_request(MINN, MINN, MINN, MAXP, MAXP, MAXP);
        send_request(MAXP, MAXP, MAXP, MINN, MINN, MINN);
        send_request(MAXP, MINN, MAXP, MINN, MAXP, MINN);
        send_request(MINN, 0, MAXP, MAXP, 0, MINN);
        send_request(MAXP, MAXP, MAXP, MAXP - ONE, MAXP, MAXP - ONE);
        send_request(MINN, MINN, MINN, MINN + 7, MINN, MINN);
        send_request(3 * ONE, 4 * ONE, 5 * ONE, 0, 0, 0);
        send_request(-1, -1, -1, 0, 0, 0);
        send_request(100 * ONE, -50 * ONE, 7 * ONE, -3 * ONE, 20 * ONE, 40 * ONE);
        send_request(0, MAXP, 0, 0, MINN, 0);
        send_request(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                     32'hf0f0_f0f0, 32'h3333_3333, 32'hcccc_cccc);

        for (int p = 0; p < 4; p++) begin
            settle_and_write(phase_eps[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < 66; n++)
                send_random();
        end

        s_axis_tvalid <= 1'b0;
        while (columns_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d look-at requests over four epsilon settings (0, max, reset, random)",
                 requests_sent);
        $display("with sender gaps and receiver back-pressure phases, including both at once.");
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
